FILE: rtl/ilp_pkg.sv
// Shared types and character constants for the integer literal parser.
package ilp_pkg;

    typedef enum logic [1:0] {
        RX_DEC,
        RX_BIN,
        RX_OCT,
        RX_HEX
    } radix_t;

    typedef struct packed {
        logic        good;
        logic        neg;
        logic [63:0] mag;
    } result_t;

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_LC_A  = 8'h61;
    localparam logic [7:0] CHR_LC_F  = 8'h66;
    localparam logic [7:0] CHR_UC_A  = 8'h41;
    localparam logic [7:0] CHR_UC_F  = 8'h46;
    localparam logic [7:0] CHR_LC_B  = 8'h62;
    localparam logic [7:0] CHR_UC_B  = 8'h42;
    localparam logic [7:0] CHR_LC_X  = 8'h78;
    localparam logic [7:0] CHR_UC_X  = 8'h58;
    localparam logic [7:0] CHR_USCORE = 8'h5F;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;

    // offsets that map a letter onto its digit value (10 for 'a' / 'A')
    localparam logic [7:0] LC_OFFSET = 8'h57;
    localparam logic [7:0] UC_OFFSET = 8'h37;

    localparam logic [63:0] MAG_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_MAX_NEG = 64'h8000_0000_0000_0000;

    function automatic logic [4:0] radix_base(input radix_t rx);
        logic [4:0] b;
        unique case (rx)
            RX_DEC: b = 5'd10;
            RX_BIN: b = 5'd2;
            RX_OCT: b = 5'd8;
            RX_HEX: b = 5'd16;
            default: b = 5'd10;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/integer_literal_parser.sv
// Integer literal parser, top level.
// Parses a signed integer literal that arrives one ASCII character per transfer
// (tlast on the final character): optional sign, a 0b / 0x / leading-zero octal
// prefix or plain decimal, digits with single underscores between them, checked
// against the signed 64-bit range. Sustained rate is one character per cycle
// while the result path is not stalled; the per-character shift-add of the
// accumulator and its limit compare form the feedback loop. One result transfer
// follows each tlast character via the result and output registers: tuser is 1
// for a valid in-range literal; tdata is its two's complement, zero if not valid.
module integer_literal_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] number
    output logic        m_tuser    // [0] ok
);

    logic             res_valid;
    logic             res_ready;
    ilp_pkg::result_t res;

    ilp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_char    (s_tdata),
        .s_last    (s_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    ilp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/ilp_digit_dec.sv
// Character to digit decoder, qualified against the active radix.
module ilp_digit_dec (
    input  logic [7:0]      char_code,
    input  ilp_pkg::radix_t radix,
    output logic            dig_valid,
    output logic [3:0]      dig_value
);

    logic       is_num;
    logic       is_lc;
    logic       is_uc;
    logic [7:0] raw;

    assign is_num = (char_code >= ilp_pkg::CHR_ZERO) && (char_code <= ilp_pkg::CHR_NINE);
    assign is_lc  = (char_code >= ilp_pkg::CHR_LC_A) && (char_code <= ilp_pkg::CHR_LC_F);
    assign is_uc  = (char_code >= ilp_pkg::CHR_UC_A) && (char_code <= ilp_pkg::CHR_UC_F);

    always_comb begin
        priority if (is_num) begin
            raw = char_code - ilp_pkg::CHR_ZERO;
        end else if (is_lc) begin
            raw = char_code - ilp_pkg::LC_OFFSET;
        end else begin
            raw = char_code - ilp_pkg::UC_OFFSET;
        end
    end

    assign dig_value = raw[3:0];
    assign dig_valid = (is_num || is_lc || is_uc)
                       && ({1'b0, raw[3:0]} < ilp_pkg::radix_base(radix));

endmodule

FILE: rtl/ilp_core.sv
// Input register, token state machine with accumulator, and final result register.
module ilp_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_char,
    input  logic             s_last,
    output logic             res_valid,
    input  logic             res_ready,
    output ilp_pkg::result_t res
);

    typedef enum logic [1:0] {
        PH_START,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    logic             a_valid_reg;
    logic [7:0]       a_char_reg;
    logic             a_last_reg;
    logic             a_adv;
    logic             b_ready;

    phase_t           phase_reg, phase_next;
    logic             neg_reg, neg_next;
    ilp_pkg::radix_t  radix_reg, radix_next;
    logic [63:0]      acc_reg, acc_next;
    logic             saw_reg, saw_next;
    logic             us_reg, us_next;
    logic             failed_reg, failed_next;

    logic             b_valid_reg;
    ilp_pkg::result_t b_data_reg, b_data_next;

    ilp_pkg::radix_t  eff_radix;
    logic             eff_saw;
    logic             dig_valid;
    logic [3:0]       dig_value;
    logic [67:0]      acc_ext;
    logic [67:0]      prod;
    logic [67:0]      sum;
    logic [63:0]      limit;
    logic             ovf;
    logic             take;
    logic             good;

    assign b_ready = !b_valid_reg || res_ready;
    assign a_adv   = a_valid_reg && (!a_last_reg || b_ready);
    assign s_ready = !a_valid_reg || a_adv;

    // radix and digit-seen flag in force for the character now in the register
    always_comb begin
        unique case (phase_reg)
            PH_DIGITS: eff_radix = radix_reg;
            PH_ZERO:   eff_radix = ilp_pkg::RX_OCT;
            default:   eff_radix = ilp_pkg::RX_DEC;
        endcase
    end
    assign eff_saw = (phase_reg == PH_ZERO) ? 1'b1 : saw_reg;

    ilp_digit_dec u_dec (
        .char_code (a_char_reg),
        .radix     (eff_radix),
        .dig_valid (dig_valid),
        .dig_value (dig_value)
    );

    // acc * base + d, with the limit check done as sum > limit
    assign acc_ext = {4'b0, acc_reg};
    always_comb begin
        unique case (eff_radix)
            ilp_pkg::RX_DEC: prod = (acc_ext << 3) + (acc_ext << 1);
            ilp_pkg::RX_BIN: prod = acc_ext << 1;
            ilp_pkg::RX_OCT: prod = acc_ext << 3;
            ilp_pkg::RX_HEX: prod = acc_ext << 4;
            default:         prod = acc_ext;
        endcase
    end
    assign sum   = prod + {64'b0, dig_value};
    assign limit = neg_reg ? ilp_pkg::MAG_MAX_NEG : ilp_pkg::MAG_MAX_POS;
    assign ovf   = sum > {4'b0, limit};

    always_comb begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        radix_next  = radix_reg;
        acc_next    = acc_reg;
        saw_next    = saw_reg;
        us_next     = us_reg;
        failed_next = failed_reg;
        take        = 1'b0;
        if (!failed_reg) begin
            unique case (phase_reg)
                PH_START, PH_SIGNED: begin
                    if ((phase_reg == PH_START)
                        && ((a_char_reg == ilp_pkg::CHR_MINUS)
                            || (a_char_reg == ilp_pkg::CHR_PLUS))) begin
                        neg_next   = (a_char_reg == ilp_pkg::CHR_MINUS);
                        phase_next = PH_SIGNED;
                    end else if (a_char_reg == ilp_pkg::CHR_ZERO) begin
                        phase_next = PH_ZERO;
                    end else begin
                        radix_next = ilp_pkg::RX_DEC;
                        phase_next = PH_DIGITS;
                        take       = 1'b1;
                    end
                end
                PH_ZERO: begin
                    phase_next = PH_DIGITS;
                    if ((a_char_reg == ilp_pkg::CHR_LC_B)
                        || (a_char_reg == ilp_pkg::CHR_UC_B)) begin
                        radix_next = ilp_pkg::RX_BIN;
                    end else if ((a_char_reg == ilp_pkg::CHR_LC_X)
                                 || (a_char_reg == ilp_pkg::CHR_UC_X)) begin
                        radix_next = ilp_pkg::RX_HEX;
                    end else begin
                        // the leading zero counts as an octal digit
                        radix_next = ilp_pkg::RX_OCT;
                        saw_next   = 1'b1;
                        acc_next   = '0;
                        take       = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    take = 1'b1;
                end
                default: begin
                    take = 1'b0;
                end
            endcase
            if (take) begin
                if (a_char_reg == ilp_pkg::CHR_USCORE) begin
                    if (!eff_saw || us_reg) begin
                        failed_next = 1'b1;
                    end else begin
                        us_next = 1'b1;
                    end
                end else if (!dig_valid) begin
                    failed_next = 1'b1;
                end else begin
                    saw_next = 1'b1;
                    us_next  = 1'b0;
                    if (ovf) begin
                        failed_next = 1'b1;
                    end else begin
                        acc_next = sum[63:0];
                    end
                end
            end
        end
    end

    assign good = !failed_next
                  && ((phase_next == PH_ZERO)
                      || ((phase_next == PH_DIGITS) && saw_next && !us_next));

    always_comb begin
        b_data_next.good = good;
        b_data_next.neg  = neg_next;
        b_data_next.mag  = (good && (phase_next != PH_ZERO)) ? acc_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            phase_reg   <= PH_START;
            neg_reg     <= 1'b0;
            radix_reg   <= ilp_pkg::RX_DEC;
            acc_reg     <= '0;
            saw_reg     <= 1'b0;
            us_reg      <= 1'b0;
            failed_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (a_adv && a_last_reg) begin
                b_valid_reg <= 1'b1;
            end else if (res_ready) begin
                b_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                if (a_last_reg) begin
                    phase_reg  <= PH_START;
                    neg_reg    <= 1'b0;
                    radix_reg  <= ilp_pkg::RX_DEC;
                    acc_reg    <= '0;
                    saw_reg    <= 1'b0;
                    us_reg     <= 1'b0;
                    failed_reg <= 1'b0;
                end else begin
                    phase_reg  <= phase_next;
                    neg_reg    <= neg_next;
                    radix_reg  <= radix_next;
                    acc_reg    <= acc_next;
                    saw_reg    <= saw_next;
                    us_reg     <= us_next;
                    failed_reg <= failed_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_char_reg <= s_char;
            a_last_reg <= s_last;
        end
        if (a_adv && a_last_reg) begin
            b_data_reg <= b_data_next;
        end
    end

    assign res_valid = b_valid_reg;
    assign res       = b_data_reg;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && b_data_reg.good && !b_data_reg.neg |-> !b_data_reg.mag[63])
        else $error("positive result beyond signed range");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !b_data_reg.good |-> b_data_reg.mag == '0)
        else $error("failed token carries a non-zero magnitude");

    a_token_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        a_adv && a_last_reg |=> (phase_reg == PH_START) && !failed_reg && (acc_reg == '0))
        else $error("state not cleared after last character");

    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg && a_adv && !a_last_reg |=> failed_reg && (acc_reg == $past(acc_reg)))
        else $error("error flag or accumulator changed after failure");
`endif

endmodule

FILE: rtl/ilp_out_reg.sv
// Output register: applies the sign and holds the result transfer.
module ilp_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    output logic             res_ready,
    input  ilp_pkg::result_t res,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,
    output logic             m_tuser
);

    logic        valid_reg;
    logic        ok_reg;
    logic [63:0] number_reg;
    logic [63:0] number_next;

    assign res_ready   = !valid_reg || m_tready;
    assign number_next = res.neg ? (64'd0 - res.mag) : res.mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            ok_reg     <= res.good;
            number_reg <= number_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = number_reg;
    assign m_tuser  = ok_reg;

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("failed token with non-zero number");
`endif

endmodule
